/* rtl/mux7_pkg.sv */
package mux7_pkg;

    localparam int SEG_W      = 8;
    localparam int SEL_W      = 4;
    localparam int BCD_W      = 4;
    localparam int SCAN_W     = 8;
    localparam int COUNT_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SCANS_PER_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_ACTIVE_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_STOPS_COUNT = 2'd2;

    localparam logic [SCAN_W-1:0] SCANS_RESET  = 8'd50;
    localparam logic [BCD_W-1:0]  BCD_MAX      = 4'd9;

    // scan control settings seen by the controller
    typedef struct packed {
        logic [SCAN_W-1:0] scans_per_count;
        logic              pause_stops_count;
    } cfg_t;

    // count update request for the digit counter
    typedef struct packed {
        logic step;
        logic clear;
    } cnt_ctl_t;

    typedef struct packed {
        logic [SEG_W-1:0]   segments;
        logic [SEL_W-1:0]   digit_select;
        logic               green_lit;
        logic               yellow_lit;
        logic               red_lit;
        logic [COUNT_W-1:0] count_value;
    } result_t;

    // common-cathode pattern, bit0 = a .. bit6 = g, dp off
    function automatic logic [SEG_W-1:0] seg_decode(input logic [BCD_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h3F;
        endcase
        return s;
    endfunction

endpackage

/* rtl/mux7_ctrl.sv */
module mux7_ctrl #(
    parameter int NUM_DIGITS = 4,
    parameter int SLOT_W     = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   start_stop_pressed,
    input  logic                   mode_pressed,
    input  logic                   reset_pressed,
    input  mux7_pkg::cfg_t         cfg,
    output logic [SLOT_W-1:0]      slot,
    output logic                   run_next,
    output logic                   red_next,
    output mux7_pkg::cnt_ctl_t     cnt_ctl
);
    import mux7_pkg::*;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic              run_reg, red_reg;
    logic              start_handled_reg, start_handled_next;
    logic              mode_handled_reg, mode_handled_next;
    logic              last_slot;
    logic [SCAN_W-1:0] scan_inc;
    logic              scan_wrap;

    assign last_slot = (slot_reg == SLOT_W'(NUM_DIGITS - 1));
    assign scan_inc  = scan_reg + SCAN_W'(1);
    assign scan_wrap = (scan_inc >= cfg.scans_per_count);

    always_comb
    begin
        slot_next          = slot_reg + SLOT_W'(1);
        scan_next          = scan_reg;
        run_next           = run_reg;
        red_next           = red_reg;
        start_handled_next = start_handled_reg;
        mode_handled_next  = mode_handled_reg;
        cnt_ctl            = '0;
        if (last_slot)
        begin
            slot_next     = '0;
            scan_next     = scan_wrap ? '0 : scan_inc;
            // count step uses the run flag from before this scan's toggle
            cnt_ctl.step  = scan_wrap && !(cfg.pause_stops_count && !run_reg);
            // toggle once per press, on the first scan it is seen held
            run_next           = run_reg ^ (start_stop_pressed & ~start_handled_reg);
            start_handled_next = start_stop_pressed;
            red_next           = red_reg ^ (mode_pressed & ~mode_handled_reg);
            mode_handled_next  = mode_pressed;
            if (reset_pressed)
            begin
                cnt_ctl.clear = 1'b1;
                scan_next     = '0;
                run_next      = 1'b0;
                red_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg          <= '0;
            scan_reg          <= '0;
            run_reg           <= 1'b0;
            red_reg           <= 1'b0;
            start_handled_reg <= 1'b0;
            mode_handled_reg  <= 1'b0;
        end
        else if (accept)
        begin
            slot_reg          <= slot_next;
            scan_reg          <= scan_next;
            run_reg           <= run_next;
            red_reg           <= red_next;
            start_handled_reg <= start_handled_next;
            mode_handled_reg  <= mode_handled_next;
        end
    end

    assign slot = slot_reg;

endmodule

/* rtl/mux7_bcd.sv */
module mux7_bcd #(
    parameter int NUM_DIGITS = 4,
    parameter int SLOT_W     = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  mux7_pkg::cnt_ctl_t            cnt_ctl,
    input  logic [SLOT_W-1:0]             rd_slot,
    output logic [mux7_pkg::BCD_W-1:0]    rd_digit,
    output logic [mux7_pkg::COUNT_W-1:0]  count_next
);
    import mux7_pkg::*;

    logic [BCD_W-1:0]   digit_reg [NUM_DIGITS];
    logic [BCD_W-1:0]   digit_inc [NUM_DIGITS];
    logic [BCD_W-1:0]   digit_next [NUM_DIGITS];
    logic [COUNT_W-1:0] bin_reg;
    logic               all_nines;

    // digit 0 is the most significant; ripple the carry from the right
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        for (int k = NUM_DIGITS - 1; k >= 0; k--)
        begin
            digit_inc[k] = digit_reg[k];
            if (carry)
            begin
                if (digit_reg[k] >= BCD_MAX)
                begin
                    digit_inc[k] = '0;
                end
                else
                begin
                    digit_inc[k] = digit_reg[k] + BCD_W'(1);
                    carry        = 1'b0;
                end
            end
        end
        all_nines = carry;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (cnt_ctl.clear)
                digit_next[k] = '0;
            else if (cnt_ctl.step)
                digit_next[k] = digit_inc[k];
            else
                digit_next[k] = digit_reg[k];
        end
    end

    // binary copy of the count, wrapping to zero together with the BCD digits
    always_comb
    begin
        if (cnt_ctl.clear)
            count_next = '0;
        else if (cnt_ctl.step)
            count_next = all_nines ? '0 : bin_reg + COUNT_W'(1);
        else
            count_next = bin_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
                digit_reg[k] <= '0;
            bin_reg <= '0;
        end
        else if (accept)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
                digit_reg[k] <= digit_next[k];
            bin_reg <= count_next;
        end
    end

    assign rd_digit = digit_reg[rd_slot];

endmodule

/* rtl/mux7_out.sv */
module mux7_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                accept,
    input  mux7_pkg::result_t   res,
    output logic                out_valid,
    input  logic                out_ready,
    output mux7_pkg::result_t   res_out
);
    import mux7_pkg::*;

    logic    out_valid_reg;
    result_t res_reg;

    // a held result is replaced in the same cycle it is taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign res_out   = res_reg;

endmodule

/* rtl/mux_7seg_decimal_counter.sv */
// An accepted item's result is captured in the output register as it is accepted.
// Throughput: 1 item per cycle while in_ready is high; slot, scan and count state update in the
// accepting cycle, so the next item may follow at once.
// in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n low, asynchronous): count, scan counter, slot, flags and press
// latches clear, output empties; scans_per_count 50, active-low select, no pause gating.
module mux_7seg_decimal_counter #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mux7_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mux7_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_stop_pressed,
    input  logic                              mode_pressed,
    input  logic                              reset_pressed,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mux7_pkg::SEG_W-1:0]        segments,
    output logic [mux7_pkg::SEL_W-1:0]        digit_select,
    output logic                              green_lit,
    output logic                              yellow_lit,
    output logic                              red_lit,
    output logic [mux7_pkg::COUNT_W-1:0]      count_value
);
    import mux7_pkg::*;

    localparam int SLOT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [SCAN_W-1:0]  scans_per_count_reg;
    logic               select_active_low_reg;
    logic               pause_stops_count_reg;
    cfg_t               cfg;
    logic               accept;
    logic [SLOT_W-1:0]  slot;
    logic               run_next, red_next;
    cnt_ctl_t           cnt_ctl;
    logic [BCD_W-1:0]   rd_digit;
    logic [COUNT_W-1:0] count_next;
    logic [SEL_W-1:0]   sel_onehot;
    result_t            res, res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scans_per_count_reg   <= SCANS_RESET;
            select_active_low_reg <= 1'b1;
            pause_stops_count_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCANS_PER_COUNT:   scans_per_count_reg   <= cfg_data;
                CFG_SELECT_ACTIVE_LOW: select_active_low_reg <= cfg_data[0];
                CFG_PAUSE_STOPS_COUNT: pause_stops_count_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    assign cfg.scans_per_count   = scans_per_count_reg;
    assign cfg.pause_stops_count = pause_stops_count_reg;

    mux7_ctrl #(
        .NUM_DIGITS (NUM_DIGITS),
        .SLOT_W     (SLOT_W)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .start_stop_pressed (start_stop_pressed),
        .mode_pressed       (mode_pressed),
        .reset_pressed      (reset_pressed),
        .cfg                (cfg),
        .slot               (slot),
        .run_next           (run_next),
        .red_next           (red_next),
        .cnt_ctl            (cnt_ctl)
    );

    mux7_bcd #(
        .NUM_DIGITS (NUM_DIGITS),
        .SLOT_W     (SLOT_W)
    ) u_bcd (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cnt_ctl    (cnt_ctl),
        .rd_slot    (slot),
        .rd_digit   (rd_digit),
        .count_next (count_next)
    );

    // digits past the fourth have no select pin
    always_comb
    begin
        for (int k = 0; k < SEL_W; k++)
            sel_onehot[k] = (int'(slot) == k);
    end

    always_comb
    begin
        res.segments     = seg_decode(rd_digit);
        res.digit_select = select_active_low_reg ? ~sel_onehot : sel_onehot;
        res.green_lit    = run_next;
        res.yellow_lit   = ~run_next;
        res.red_lit      = red_next;
        res.count_value  = count_next;
    end

    mux7_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .accept    (accept),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign segments     = res_out.segments;
    assign digit_select = res_out.digit_select;
    assign green_lit    = res_out.green_lit;
    assign yellow_lit   = res_out.yellow_lit;
    assign red_lit      = res_out.red_lit;
    assign count_value  = res_out.count_value;

endmodule

/* rtl/mux7_checker.sv */
module mux7_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [mux7_pkg::SEG_W-1:0]        segments,
    input logic [mux7_pkg::SEL_W-1:0]        digit_select,
    input logic                              green_lit,
    input logic                              yellow_lit,
    input logic [mux7_pkg::COUNT_W-1:0]      count_value
);
    import mux7_pkg::*;

    // run and pause lamps are always opposite
    a_lamps_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (green_lit != yellow_lit))
        else $error("green and yellow lamps agree");

    // decimal point is never driven
    a_dp_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !segments[SEG_W-1])
        else $error("decimal point lit");

    // input side stalls only behind a held result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low with output free");

    // output empties when taken and nothing new arrives
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !in_valid) |=> !out_valid)
        else $error("result repeated");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(segments) && $stable(digit_select)
             && $stable(count_value)))
        else $error("stalled result changed");

endmodule

bind mux_7seg_decimal_counter mux7_checker u_mux7_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segments     (segments),
    .digit_select (digit_select),
    .green_lit    (green_lit),
    .yellow_lit   (yellow_lit),
    .count_value  (count_value)
);

/* tb/tb.sv */
module tb;
    import mux7_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 24;
    localparam int RAND_ITEMS     = 200;
    // one count step per scan, buttons never reset the count
    localparam int SWEEP_ITEMS    = 200;

    typedef struct packed {
        logic    ss;
        logic    md;
        logic    rs;
        logic    fixed;
        result_t want;
    } tick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic start_stop_pressed = 1'b0;
    logic mode_pressed = 1'b0;
    logic reset_pressed = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [SEG_W-1:0] segments;
    logic [SEL_W-1:0] digit_select;
    logic green_lit;
    logic yellow_lit;
    logic red_lit;
    logic [COUNT_W-1:0] count_value;

    // display model state and its copy of the registers
    logic [1:0]       m_slot = '0;
    logic [SCAN_W-1:0] m_scans = '0;
    logic [BCD_W-1:0] m_digit [4];
    logic             m_run = 1'b0;
    logic             m_red = 1'b0;
    logic             m_ss_held = 1'b0;
    logic             m_md_held = 1'b0;
    logic [SCAN_W-1:0] c_scans = SCANS_RESET;
    logic             c_sel_low = 1'b1;
    logic             c_pause = 1'b0;

    result_t expected_display [$];
    tick_t   pending_ticks [$];
    tick_t   tk;
    result_t pred;
    result_t want;

    int errors = 0;
    int checked = 0;
    int sent = 0;
    int wraps = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int rcv_left = 0;
    logic timed_out = 1'b0;
    logic ss_lvl = 1'b0;
    logic md_lvl = 1'b0;

    // after reset: scans_per_count 50, active-low select, no pause gating
    tick_t dir_tab [DIR_ROWS] = '{
        '{1'b0, 1'b0, 1'b0, 1'b1, '{8'h3F, 4'hE, 1'b0, 1'b1, 1'b0, 14'd0}},
        // buttons mid-scan are ignored
        '{1'b1, 1'b1, 1'b1, 1'b1, '{8'h3F, 4'hD, 1'b0, 1'b1, 1'b0, 14'd0}},
        '{1'b0, 1'b0, 1'b1, 1'b1, '{8'h3F, 4'hB, 1'b0, 1'b1, 1'b0, 14'd0}},
        // end of scan: start/stop and mode toggle both flags
        '{1'b1, 1'b1, 1'b0, 1'b1, '{8'h3F, 4'h7, 1'b1, 1'b0, 1'b1, 14'd0}},
        // held buttons: no second toggle
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b1, 1'b0, '0},
        // reset together with both toggles
        '{1'b1, 1'b1, 1'b1, 1'b1, '{8'h3F, 4'h7, 1'b0, 1'b1, 1'b0, 14'd0}},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b1, 1'b1, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b1, 1'b0, '0},
        // toggles set both flags, reset wins
        '{1'b1, 1'b1, 1'b1, 1'b1, '{8'h3F, 4'h7, 1'b0, 1'b1, 1'b0, 14'd0}}
    };

    mux_7seg_decimal_counter dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .start_stop_pressed (start_stop_pressed),
        .mode_pressed       (mode_pressed),
        .reset_pressed      (reset_pressed),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .segments           (segments),
        .digit_select       (digit_select),
        .green_lit          (green_lit),
        .yellow_lit         (yellow_lit),
        .red_lit            (red_lit),
        .count_value        (count_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic next_display(input logic ss, input logic md, input logic rs,
                                output result_t r);
        logic [1:0] s;
        logic carry;
        int k;
        s = m_slot;
        case (m_digit[s])
            4'd0:    r.segments = 8'h3F;
            4'd1:    r.segments = 8'h06;
            4'd2:    r.segments = 8'h5B;
            4'd3:    r.segments = 8'h4F;
            4'd4:    r.segments = 8'h66;
            4'd5:    r.segments = 8'h6D;
            4'd6:    r.segments = 8'h7D;
            4'd7:    r.segments = 8'h07;
            4'd8:    r.segments = 8'h7F;
            4'd9:    r.segments = 8'h6F;
            default: r.segments = 8'h3F;
        endcase
        r.digit_select = 4'b0001 << s;
        if (c_sel_low)
            r.digit_select = ~r.digit_select;
        if (s == 2'd3)
        begin
            m_slot = 2'd0;
            m_scans = m_scans + 8'd1;
            if (m_scans >= c_scans)
            begin
                // scan counter restarts even when the count step is gated
                m_scans = '0;
                if (!(c_pause && !m_run))
                begin
                    carry = 1'b1;
                    for (k = 3; k >= 0; k--)
                    begin
                        if (carry)
                        begin
                            if (m_digit[k] >= BCD_MAX)
                                m_digit[k] = '0;
                            else
                            begin
                                m_digit[k] = m_digit[k] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                    if (carry)
                        wraps++;
                end
            end
            if (ss)
            begin
                if (!m_ss_held)
                begin
                    m_ss_held = 1'b1;
                    m_run = ~m_run;
                end
            end
            else
                m_ss_held = 1'b0;
            if (md)
            begin
                if (!m_md_held)
                begin
                    m_md_held = 1'b1;
                    m_red = ~m_red;
                end
            end
            else
                m_md_held = 1'b0;
            if (rs)
            begin
                for (k = 0; k < 4; k++)
                    m_digit[k] = '0;
                m_scans = '0;
                m_run = 1'b0;
                m_red = 1'b0;
            end
        end
        else
            m_slot = s + 2'd1;
        r.green_lit = m_run;
        r.yellow_lit = ~m_run;
        r.red_lit = m_red;
        r.count_value = COUNT_W'(m_digit[0] * 1000 + m_digit[1] * 100
                                 + m_digit[2] * 10 + m_digit[3]);
    endtask

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_display.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: seg %h sel %h count %0d",
                                 segments, digit_select, count_value);
                end
                else
                begin
                    want = expected_display.pop_front();
                    checked++;
                    if (segments !== want.segments || digit_select !== want.digit_select
                        || green_lit !== want.green_lit || yellow_lit !== want.yellow_lit
                        || red_lit !== want.red_lit || count_value !== want.count_value)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch (exp/got): seg %h/%h sel %h/%h ",
                                      "grn %b/%b yel %b/%b red %b/%b count %0d/%0d"},
                                     want.segments, segments,
                                     want.digit_select, digit_select,
                                     want.green_lit, green_lit,
                                     want.yellow_lit, yellow_lit,
                                     want.red_lit, red_lit,
                                     want.count_value, count_value);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                tk = pending_ticks.pop_front();
                next_display(start_stop_pressed, mode_pressed, reset_pressed, pred);
                expected_display.push_back(tk.fixed ? tk.want : pred);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCANS_PER_COUNT:   c_scans = cfg_data;
                    CFG_SELECT_ACTIVE_LOW: c_sel_low = cfg_data[0];
                    CFG_PAUSE_STOPS_COUNT: c_pause = cfg_data[0];
                    default: ;
                endcase
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                    timed_out = 1'b1;
            end
        end
    end

    // receiver: short stalls, short ready runs, now and then a long ready run
    always @(negedge clk)
    begin
        if (rcv_left == 0)
        begin
            if (out_ready && $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b0;
                rcv_left <= $urandom_range(0, 6);
            end
            else
            begin
                out_ready <= 1'b1;
                rcv_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 15);
            end
        end
        else
            rcv_left <= rcv_left - 1;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_tick(input logic ss, input logic md, input logic rs,
                             input logic fixed, input result_t exp_r);
        tick_t t;
        int gap;
        t = '{ss, md, rs, fixed, exp_r};
        pending_ticks.push_back(t);
        start_stop_pressed = ss;
        mode_pressed = md;
        reset_pressed = rs;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // button levels mostly held across scans, with some per-item noise
    task automatic random_ticks(input int n, input int rst_odds);
        int i;
        logic ss;
        logic md;
        logic rs;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                ss_lvl = ~ss_lvl;
            if ($urandom_range(0, 5) == 0)
                md_lvl = ~md_lvl;
            if ($urandom_range(0, 7) == 0)
            begin
                ss = 1'($urandom_range(0, 1));
                md = 1'($urandom_range(0, 1));
            end
            else
            begin
                ss = ss_lvl;
                md = md_lvl;
            end
            rs = (rst_odds != 0) && ($urandom_range(1, rst_odds) == 1);
            send_tick(ss, md, rs, 1'b0, '0);
        end
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (expected_display.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        wait (timed_out);
        $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int i;
        for (i = 0; i < 4; i++)
            m_digit[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_tick(dir_tab[i].ss, dir_tab[i].md, dir_tab[i].rs,
                      dir_tab[i].fixed, dir_tab[i].want);
        random_ticks(RAND_ITEMS, 40);

        // step every scan, active-high select, counting gated while paused
        settle();
        write_reg(CFG_SCANS_PER_COUNT, 8'd0);
        write_reg(CFG_SELECT_ACTIVE_LOW, 8'd0);
        write_reg(CFG_PAUSE_STOPS_COUNT, 8'd1);
        random_ticks(RAND_ITEMS, 40);

        // slowest rate, no resets so the scan counter climbs
        settle();
        write_reg(CFG_SCANS_PER_COUNT, 8'd255);
        write_reg(CFG_SELECT_ACTIVE_LOW, 8'd1);
        write_reg(CFG_PAUSE_STOPS_COUNT, 8'd0);
        write_reg(CFG_UNUSED, 8'($urandom));
        random_ticks(RAND_ITEMS, 0);

        // lowered below the scan counter: steps at the end of the next scan
        settle();
        write_reg(CFG_SCANS_PER_COUNT, 8'd3);
        random_ticks(RAND_ITEMS, 40);

        settle();
        write_reg(CFG_SCANS_PER_COUNT, 8'd1);
        write_reg(CFG_SELECT_ACTIVE_LOW, 8'd0);
        random_ticks(RAND_ITEMS, 40);

        // free counting, one step per scan
        settle();
        write_reg(CFG_SCANS_PER_COUNT, 8'd0);
        write_reg(CFG_PAUSE_STOPS_COUNT, 8'd0);
        random_ticks(SWEEP_ITEMS, 0);

        settle();
        $display("%0d items sent, %0d results checked, %0d mismatches, %0d count wraps",
                 sent, checked, errors, wraps);
        $display("scan rates 50/0/255/3/1, both select polarities, pause gating on and off");
        if (errors == 0 && expected_display.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
